// ===== design/pit_pkg.sv =====
// Shared types and constants for the point-in-triangle test.
// No dependencies; compile first.
`default_nettype none

package pit_pkg;

  // Register stages from point beat to result beat
  localparam int PIT_STAGES = 5;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 2;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
  localparam cfg_idx_t VTX_ZERO = 2'd0;
  localparam cfg_idx_t VTX_ONE  = 2'd1;
  localparam cfg_idx_t VTX_TWO  = 2'd2;

  // A vertex register keeps at most this many low bits of the written data
  localparam int CFG_HOLD_BITS = 64;

  // Per-stage load enables from the pipeline control to the edge lanes
  typedef struct packed {
    logic [PIT_STAGES-1:0] load;
  } pit_ctl_t;

endpackage

`default_nettype wire

// ===== design/pit_if.sv =====
// Valid/ready channel interfaces: configuration writes, point beats, result beats.
// Depends on pit_pkg for the register index type.
`default_nettype none

interface pit_cfg_if #(
  parameter int DATA_BITS = 48
);
  logic                 valid;
  logic                 ready;
  pit_pkg::cfg_idx_t    index;
  logic [DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface pit_point_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface pit_flag_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink   (input valid, inside_res, output ready);
endinterface

`default_nettype wire

// ===== design/pit_ctrl.sv =====
// Pipeline control: stage valid bits and the per-stage load enables.
// Depends on pit_pkg (PIT_STAGES, pit_ctl_t).
`default_nettype none

module pit_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output pit_pkg::pit_ctl_t ctl
);
  import pit_pkg::*;

  logic [PIT_STAGES-1:0] vld;
  logic [PIT_STAGES-1:0] load;

  // A stage loads when it is empty or its successor loads
  always_comb begin
    load[PIT_STAGES-1] = !vld[PIT_STAGES-1] || out_ready;
    for (int k = PIT_STAGES - 2; k >= 0; k--) begin
      load[k] = !vld[k] || load[k+1];
    end
  end

  // Advance valid bits along with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (load[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < PIT_STAGES; k++) begin
        if (load[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign in_ready  = load[0];
  assign out_valid = vld[PIT_STAGES-1];
  assign ctl       = '{load: load};

`ifndef SYNTHESIS
  a_hold_first: assert property (@(posedge clk) disable iff (rst)
    vld[0] && !load[0] |=> vld[0])
    else $error("first stage dropped a stalled beat");
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (&vld) && !out_ready |-> !in_ready)
    else $error("point beat taken into a full, stalled pipeline");
  a_bubble_open: assert property (@(posedge clk) disable iff (rst)
    !(&vld) |-> in_ready)
    else $error("pipeline has a bubble but refuses a point beat");
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire

// ===== design/pit_edge.sv =====
// One edge lane: side test of the point against one triangle edge, five stages.
// Depends on pit_pkg (pit_ctl_t); enables come from pit_ctrl.
`default_nettype none

module pit_edge #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  pit_pkg::pit_ctl_t            ctl,
  input  logic signed [COORD_BITS-1:0] vi [3],
  input  logic signed [COORD_BITS-1:0] vj [3],
  input  logic signed [COORD_BITS-1:0] vo [3],
  input  logic signed [COORD_BITS-1:0] p  [3],
  output logic                         outside
);
  import pit_pkg::*;

  // With c = e x f and n = c x e: f.n = |c|^2 >= 0 and g.n = c.(e x g).
  // So the point is outside this edge exactly when c != 0 and c.(e x g) < 0.
  localparam int EW  = COORD_BITS + 1;       // edge and point vectors
  localparam int CW  = 2 * COORD_BITS + 3;   // cross products
  localparam int LW  = COORD_BITS + 2;       // low slice of e x g
  localparam int HW  = CW - LW;              // high slice of e x g
  localparam int PLW = CW + LW + 1;
  localparam int PHW = CW + HW;
  localparam int SLW = PLW + 2;
  localparam int SHW = PHW + 2;
  localparam int DW  = 2 * CW + 2;

  logic signed [EW-1:0]  e [3];
  logic signed [EW-1:0]  f [3];
  logic signed [EW-1:0]  g [3];
  logic signed [CW-1:0]  c [3];
  logic signed [CW-1:0]  d [3];
  logic signed [LW:0]    dlo [3];
  logic signed [HW-1:0]  dhi [3];
  logic signed [PLW-1:0] pl [3];
  logic signed [PHW-1:0] ph [3];
  logic                  nz_s2;
  logic signed [SLW-1:0] sum_l;
  logic signed [SHW-1:0] sum_h;
  logic                  nz_s3;
  logic signed [DW-1:0]  dot;

  // Stage 0: edge vector, opposite-vertex vector, point vector
  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      for (int k = 0; k < 3; k++) begin
        e[k] <= EW'(vj[k]) - EW'(vi[k]);
        f[k] <= EW'(vo[k]) - EW'(vi[k]);
        g[k] <= EW'(p[k])  - EW'(vi[k]);
      end
    end
  end

  // Stage 1: c = e x f and d = e x g
  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      c[0] <= CW'(e[1]) * CW'(f[2]) - CW'(e[2]) * CW'(f[1]);
      c[1] <= CW'(e[2]) * CW'(f[0]) - CW'(e[0]) * CW'(f[2]);
      c[2] <= CW'(e[0]) * CW'(f[1]) - CW'(e[1]) * CW'(f[0]);
      d[0] <= CW'(e[1]) * CW'(g[2]) - CW'(e[2]) * CW'(g[1]);
      d[1] <= CW'(e[2]) * CW'(g[0]) - CW'(e[0]) * CW'(g[2]);
      d[2] <= CW'(e[0]) * CW'(g[1]) - CW'(e[1]) * CW'(g[0]);
    end
  end

  // Split d into an unsigned low slice and a signed high slice
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dlo[k] = $signed({1'b0, d[k][LW-1:0]});
      dhi[k] = $signed(d[k][CW-1:LW]);
    end
  end

  // Stage 2: partial products of c.d, degenerate-edge flag
  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      for (int k = 0; k < 3; k++) begin
        pl[k] <= PLW'(c[k]) * PLW'(dlo[k]);
        ph[k] <= PHW'(c[k]) * PHW'(dhi[k]);
      end
      nz_s2 <= (c[0] != '0) || (c[1] != '0) || (c[2] != '0);
    end
  end

  // Stage 3: sum the low and high partial products separately
  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      sum_l <= SLW'(pl[0]) + SLW'(pl[1]) + SLW'(pl[2]);
      sum_h <= SHW'(ph[0]) + SHW'(ph[1]) + SHW'(ph[2]);
      nz_s3 <= nz_s2;
    end
  end

  // Stage 4: recombine c.d and take its sign
  always_comb begin
    dot = (DW'(sum_h) <<< LW) + DW'(sum_l);
  end

  always_ff @(posedge clk) begin
    if (ctl.load[4]) begin
      outside <= nz_s3 && dot[DW-1];
    end
  end

endmodule

`default_nettype wire

// ===== design/point_in_triangle_test.sv =====
// Point-in-triangle test top level: vertex registers, an edge lane per edge, control.
// Depends on pit_pkg, pit_if, pit_ctrl and pit_edge.
`default_nettype none

// Tests each point beat against the triangle held in vertex_zero, vertex_one and
// vertex_two (x in the low lane, then y, then z, each a signed COORD_BITS value)
// and returns one inside_res beat per point, in order: 1 when the point lies
// inside or on the triangle, or the triangle is degenerate. The block takes one
// point every cycle while result.ready is held high, and each point passes the
// five-stage edge pipeline (difference vectors, cross products, split partial
// products of the final dot product, two partial sums, recombine and sign). A
// stall on the result side backs up one stage at a time, so empty stages keep
// taking points. Vertex writes are always accepted, take effect on the next
// cycle, and must be made only while no point is in flight; a write to an index
// past the third vertex is dropped, and register bits above bit 63 read as zero.
module point_in_triangle_test #(
  parameter int COORD_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  pit_cfg_if.sink           cfg,
  pit_point_if.sink         point,
  pit_flag_if.source        result
);
  import pit_pkg::*;

  localparam int REG_BITS = 3 * COORD_BITS;
  localparam int HOLD     = (REG_BITS > CFG_HOLD_BITS) ? CFG_HOLD_BITS : REG_BITS;
  localparam logic [REG_BITS-1:0] HOLD_MASK = {REG_BITS{1'b1}} >> (REG_BITS - HOLD);

  logic [REG_BITS-1:0]          vtx [3];
  logic signed [COORD_BITS-1:0] vc  [3][3];
  logic signed [COORD_BITS-1:0] pc  [3];
  logic [2:0]                   outside;
  pit_ctl_t                     ctl;

  // Vertex registers: write on a configuration beat, drop unknown indexes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        vtx[i] <= '0;
      end
    end else if (cfg.valid) begin
      unique case (cfg.index)
        VTX_ZERO: vtx[0] <= cfg.data & HOLD_MASK;
        VTX_ONE:  vtx[1] <= cfg.data & HOLD_MASK;
        VTX_TWO:  vtx[2] <= cfg.data & HOLD_MASK;
        default: ;
      endcase
    end
  end

  // Unpack coordinate lanes
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        vc[i][k] = $signed(vtx[i][k*COORD_BITS +: COORD_BITS]);
      end
    end
    pc[0] = point.point_x;
    pc[1] = point.point_y;
    pc[2] = point.point_z;
  end

  pit_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (point.valid),
    .in_ready  (point.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .ctl       (ctl)
  );

  // One lane per edge: vertex i to vertex i+1, opposite vertex i+2
  for (genvar i = 0; i < 3; i++) begin : g_edge
    localparam int J = (i + 1) % 3;
    localparam int O = (i + 2) % 3;

    pit_edge #(
      .COORD_BITS (COORD_BITS)
    ) u_edge (
      .clk     (clk),
      .ctl     (ctl),
      .vi      (vc[i]),
      .vj      (vc[J]),
      .vo      (vc[O]),
      .p       (pc),
      .outside (outside[i])
    );
  end

  assign result.inside_res = ~|outside;

endmodule

`default_nettype wire
